// ----- rtl/core/bclc_pkg.sv -----
package bclc_pkg;

	// Configuration port geometry: eight registers on an 8-byte stride
	localparam int unsigned ADDR_W = 6;
	localparam int unsigned DATA_W = 64;

	// Register indexes, taken from paddr[5:3]
	localparam logic [2:0] REG_CAPACITY   = 3'd0;
	localparam logic [2:0] REG_MAX_CHARGE = 3'd1;
	localparam logic [2:0] REG_MIN_CHARGE = 3'd2;
	localparam logic [2:0] REG_ADJ_STEP   = 3'd3;
	localparam logic [2:0] REG_VOLT_LIM   = 3'd4;
	localparam logic [2:0] REG_TAPER      = 3'd5;
	localparam logic [2:0] REG_SOC_LIM    = 3'd6;
	localparam logic [2:0] REG_AUTO_TRIM  = 3'd7;

	localparam logic [15:0] SOC_LIM_RESET = 16'h6400;

	// Field widths
	localparam int unsigned MA_W   = 22;
	localparam int unsigned SOC_W  = 7;
	localparam int unsigned VOLT_W = 16;
	localparam int unsigned CUR_W  = 32;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned TIER_W = 2;
	localparam int unsigned V10_W  = 13;

	// Fixed thresholds
	localparam logic signed [CUR_W-1:0] CHARGING_MIN_MA = 32'sd5;
	localparam logic [VOLT_W:0] FULL_MARGIN_LO = 17'd30;
	localparam logic [VOLT_W:0] FULL_MARGIN_HI = 17'd50;
	localparam logic [SOC_W-1:0] SOC_RECHARGE_MAX = 7'd97;
	localparam logic [7:0] SOC_CHECK_OFF = 8'd100;
	localparam logic [MA_W-1:0] MA_MAX = {MA_W{1'b1}};

	// Divide a 16-bit value by ten: multiply by 52429 and keep bits [31:19]
	localparam logic [32:0] DIV10_MUL = 33'd52429;
	localparam int unsigned DIV10_SHIFT = 19;

	// Tier codes
	localparam logic [TIER_W-1:0] TIER_BULK = 2'd0;
	localparam logic [TIER_W-1:0] TIER_ONE  = 2'd1;
	localparam logic [TIER_W-1:0] TIER_TWO  = 2'd2;

	localparam int unsigned DIV_STEPS = MA_W;
	localparam int unsigned CNT_W = 5;

	typedef struct packed {
		logic [MA_W-1:0] capacity_ma;
		logic [MA_W-1:0] max_charge_ma;
		logic [MA_W-1:0] min_charge_ma;
		logic [MA_W-1:0] adjust_step_ma;
		logic [47:0]     voltage_limits;
		logic [31:0]     taper_tiers;
		logic [15:0]     soc_limits;
		logic            auto_trim_on;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic step;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_status_t;

endpackage

// ----- rtl/core/bclc_if.sv -----
interface bclc_in_if;
	logic                     valid;
	logic                     ready;
	logic [6:0]               soc_percent;
	logic [15:0]              pack_voltage;
	logic signed [31:0]       pack_current_ma;
	logic [31:0]              now_seconds;

	modport source (output valid, soc_percent, pack_voltage, pack_current_ma, now_seconds,
		input ready);
	modport sink (input valid, soc_percent, pack_voltage, pack_current_ma, now_seconds,
		output ready);
endinterface

interface bclc_out_if;
	logic        valid;
	logic        ready;
	logic [21:0] charge_limit_ma;
	logic        charge_allowed;
	logic        discharge_allowed;
	logic [1:0]  tier;
	logic        settings_changed;

	modport source (output valid, charge_limit_ma, charge_allowed, discharge_allowed, tier,
		settings_changed, input ready);
	modport sink (input valid, charge_limit_ma, charge_allowed, discharge_allowed, tier,
		settings_changed, output ready);
endinterface

// ----- rtl/core/bclc_cfg_regs.sv -----
module bclc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bclc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bclc_pkg::DATA_W-1:0]   pwdata,
	output logic [bclc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output bclc_pkg::cfg_t                cfg
);
	import bclc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity_ma    <= '0;
			cfg_q.max_charge_ma  <= '0;
			cfg_q.min_charge_ma  <= '0;
			cfg_q.adjust_step_ma <= '0;
			cfg_q.voltage_limits <= '0;
			cfg_q.taper_tiers    <= '0;
			cfg_q.soc_limits     <= SOC_LIM_RESET;
			cfg_q.auto_trim_on   <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CAPACITY:   cfg_q.capacity_ma    <= pwdata[MA_W-1:0];
				REG_MAX_CHARGE: cfg_q.max_charge_ma  <= pwdata[MA_W-1:0];
				REG_MIN_CHARGE: cfg_q.min_charge_ma  <= pwdata[MA_W-1:0];
				REG_ADJ_STEP:   cfg_q.adjust_step_ma <= pwdata[MA_W-1:0];
				REG_VOLT_LIM:   cfg_q.voltage_limits <= pwdata[47:0];
				REG_TAPER:      cfg_q.taper_tiers    <= pwdata[31:0];
				REG_SOC_LIM:    cfg_q.soc_limits     <= pwdata[15:0];
				REG_AUTO_TRIM:  cfg_q.auto_trim_on   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_CAPACITY:   prdata = DATA_W'(cfg_q.capacity_ma);
			REG_MAX_CHARGE: prdata = DATA_W'(cfg_q.max_charge_ma);
			REG_MIN_CHARGE: prdata = DATA_W'(cfg_q.min_charge_ma);
			REG_ADJ_STEP:   prdata = DATA_W'(cfg_q.adjust_step_ma);
			REG_VOLT_LIM:   prdata = DATA_W'(cfg_q.voltage_limits);
			REG_TAPER:      prdata = DATA_W'(cfg_q.taper_tiers);
			REG_SOC_LIM:    prdata = DATA_W'(cfg_q.soc_limits);
			REG_AUTO_TRIM:  prdata = DATA_W'(cfg_q.auto_trim_on);
			default:        prdata = '0;
		endcase
	end

endmodule

// ----- rtl/core/bclc_ctrl.sv -----
module bclc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output bclc_pkg::dp_cmd_t      cmd,
	input  bclc_pkg::dp_status_t   status
);
	import bclc_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOAD   = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// Issue datapath commands from the current state
	always_comb begin
		cmd.capture = in_valid && in_ready;
		cmd.load    = (state_q == ST_LOAD);
		cmd.step    = (state_q == ST_DIV) && !status.div_done;
		cmd.update  = (state_q == ST_UPDATE) && slot_free;
	end

	// Advance through capture, divide and update
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (cmd.capture) state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_DIV;
			ST_DIV:    if (status.div_done) state_d = ST_UPDATE;
			ST_UPDATE: if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Hold the result until the sink takes the transfer
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/bclc_datapath.sv -----
module bclc_datapath #(
	parameter int unsigned TRIM_INTERVAL_S = 60
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bclc_pkg::cfg_t                    cfg,
	input  bclc_pkg::dp_cmd_t                 cmd,
	output bclc_pkg::dp_status_t              status,
	input  logic [bclc_pkg::SOC_W-1:0]        soc_percent,
	input  logic [bclc_pkg::VOLT_W-1:0]       pack_voltage,
	input  logic signed [bclc_pkg::CUR_W-1:0] pack_current_ma,
	input  logic [bclc_pkg::TIME_W-1:0]       now_seconds,
	output logic [bclc_pkg::MA_W-1:0]         charge_limit_ma,
	output logic                              charge_allowed,
	output logic                              discharge_allowed,
	output logic [bclc_pkg::TIER_W-1:0]       tier,
	output logic                              settings_changed
);
	import bclc_pkg::*;

	// Captured update
	logic [SOC_W-1:0]        soc_q;
	logic [VOLT_W-1:0]       volt_q;
	logic signed [CUR_W-1:0] cur_q;
	logic [TIME_W-1:0]       now_q;

	// Divider and scaled voltages
	logic [V10_W-1:0] full10_q, over10_q;
	logic [MA_W-1:0]  quot_q;
	logic [7:0]       rem_q;
	logic [7:0]       div_d_q;
	logic [CNT_W-1:0] cnt_q;

	// Controller state
	logic [MA_W-1:0]   trim_q, active_q;
	logic [TIME_W-1:0] last_time_q;
	logic [TIER_W-1:0] prev_tier_q;
	logic              armed_q, charge_q, dis_q;

	// Result register
	logic [MA_W-1:0]   res_limit_q;
	logic              res_charge_q, res_dis_q, res_changed_q;
	logic [TIER_W-1:0] res_tier_q;

	logic [15:0] full_v, over_v, dis_v;
	logic [7:0]  s1, d1, s2, d2, low_soc, high_soc;
	logic        t2_hit, t1_hit;
	logic [TIER_W-1:0] tier_sel;
	logic [32:0] full_prod, over_prod;
	logic [8:0]  div_trial;
	logic        div_ge;

	logic              cap_nz, armed_n, charging, dist_ok;
	logic              v_gt_full, v_lt_lo, v_lt_hi;
	logic [MA_W-1:0]   base, trim0, trim1, lim0, lim;
	logic [TIME_W-1:0] elapsed;
	logic [MA_W:0]     trim_sum, head_need, lim_diff;
	logic              path_a, c1, c2, dn, high_block, ov_block, lim_chg, changed;
	logic [TIME_W-1:0] last_n;

	assign full_v   = cfg.voltage_limits[15:0];
	assign over_v   = cfg.voltage_limits[31:16];
	assign dis_v    = cfg.voltage_limits[47:32];
	assign s1       = cfg.taper_tiers[7:0];
	assign d1       = cfg.taper_tiers[15:8];
	assign s2       = cfg.taper_tiers[23:16];
	assign d2       = cfg.taper_tiers[31:24];
	assign low_soc  = cfg.soc_limits[7:0];
	assign high_soc = cfg.soc_limits[15:8];

	// Pick the taper tier, tier two first
	assign t2_hit   = (s2 != 8'd0) && ({1'b0, soc_q} >= s2) && (d2 != 8'd0);
	assign t1_hit   = (s1 != 8'd0) && ({1'b0, soc_q} >= s1) && (d1 != 8'd0);
	assign tier_sel = t2_hit ? TIER_TWO : (t1_hit ? TIER_ONE : TIER_BULK);

	assign full_prod = 33'(full_v) * DIV10_MUL;
	assign over_prod = 33'(over_v) * DIV10_MUL;

	// One restoring quotient bit per step
	assign div_trial = {rem_q, quot_q[MA_W-1]};
	assign div_ge    = (div_trial >= {1'b0, div_d_q});

	assign status.div_done = (cnt_q == CNT_W'(DIV_STEPS));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			soc_q  <= soc_percent;
			volt_q <= pack_voltage;
			cur_q  <= pack_current_ma;
			now_q  <= now_seconds;
		end
		if (cmd.load) begin
			full10_q <= full_prod[DIV10_SHIFT +: V10_W];
			over10_q <= over_prod[DIV10_SHIFT +: V10_W];
			quot_q   <= cfg.capacity_ma;
			rem_q    <= '0;
			div_d_q  <= t2_hit ? d2 : d1;
		end else if (cmd.step) begin
			quot_q <= {quot_q[MA_W-2:0], div_ge};
			rem_q  <= div_ge ? 8'(div_trial - {1'b0, div_d_q}) : div_trial[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Work out tier, trim, limit and enables for the update
	always_comb begin
		cap_nz  = (cfg.capacity_ma != '0);
		armed_n = armed_q || ((over_v != 16'd0) && (full_v != 16'd0)
			&& (cfg.adjust_step_ma != '0) && (cfg.min_charge_ma != '0));
		base    = (tier_sel == TIER_BULK) ? cfg.max_charge_ma : quot_q;
		trim0   = (tier_sel != prev_tier_q) ? '0 : trim_q;

		elapsed   = (now_q >= last_time_q) ? (now_q - last_time_q) : (last_time_q - now_q);
		dist_ok   = (elapsed >= TIME_W'(TRIM_INTERVAL_S));
		charging  = (cur_q >= CHARGING_MIN_MA);
		v_gt_full = (volt_q > VOLT_W'(full10_q));
		v_lt_lo   = ((17'(volt_q) + FULL_MARGIN_LO) < 17'(full10_q));
		v_lt_hi   = ((17'(volt_q) + FULL_MARGIN_HI) < 17'(full10_q));

		trim_sum  = 23'(trim0) + 23'(cfg.adjust_step_ma);
		head_need = 23'(trim0) + 23'(cfg.min_charge_ma);

		trim1  = trim0;
		c1     = charge_q;
		last_n = last_time_q;
		path_a = 1'b0;
		if (cap_nz && cfg.auto_trim_on && armed_n) begin
			if (charging && v_gt_full && dist_ok) begin
				path_a = 1'b1;
				last_n = now_q;
				if (23'(base) > head_need) begin
					trim1 = trim_sum[MA_W] ? MA_MAX : trim_sum[MA_W-1:0];
				end else begin
					c1 = 1'b0;
				end
			end else if (charging && v_lt_lo && (trim0 != '0)) begin
				if (trim0 >= cfg.adjust_step_ma) begin
					trim1 = trim0 - cfg.adjust_step_ma;
				end
			end else if (v_lt_hi && !charge_q && (soc_q <= SOC_RECHARGE_MAX)) begin
				c1 = 1'b1;
			end
		end

		// Base minus trim, clamped at zero, raised to the floor
		lim_diff = 23'(base) - 23'(trim1);
		lim0     = lim_diff[MA_W] ? '0 : lim_diff[MA_W-1:0];
		lim      = (lim0 < cfg.min_charge_ma) ? cfg.min_charge_ma : lim0;
		lim_chg  = cap_nz && (lim != active_q);

		dn = (low_soc != 8'd0) ? ({1'b0, soc_q} > low_soc) : dis_q;

		high_block = (high_soc < SOC_CHECK_OFF) && ({1'b0, soc_q} >= high_soc) && c1;
		ov_block   = (over_v > dis_v) && (volt_q >= VOLT_W'(over10_q));
		c2         = !(high_block || ov_block);

		changed = lim_chg || (dn != dis_q) || (c1 != charge_q) || (c2 != c1);
	end

	// Commit state on the update cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q      <= '0;
			active_q    <= '0;
			last_time_q <= '0;
			prev_tier_q <= TIER_BULK;
			armed_q     <= 1'b0;
			charge_q    <= 1'b1;
			dis_q       <= 1'b1;
		end else if (cmd.update) begin
			armed_q  <= armed_n;
			charge_q <= c2;
			dis_q    <= dn;
			if (cap_nz) begin
				trim_q      <= trim1;
				active_q    <= lim;
				prev_tier_q <= tier_sel;
				if (path_a) begin
					last_time_q <= last_n;
				end
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_limit_q   <= cap_nz ? lim : active_q;
			res_charge_q  <= c2;
			res_dis_q     <= dn;
			res_tier_q    <= cap_nz ? tier_sel : prev_tier_q;
			res_changed_q <= changed;
		end
	end

	assign charge_limit_ma   = res_limit_q;
	assign charge_allowed    = res_charge_q;
	assign discharge_allowed = res_dis_q;
	assign tier              = res_tier_q;
	assign settings_changed  = res_changed_q;

endmodule

// ----- rtl/core/battery_charge_limit_controller_unit.sv -----
// Battery charge limit controller. One battery update is taken per transfer on
// in_ch and yields one result on out_ch. After the accepting edge, a load state
// loads the divider and scales the voltage limits by ten; the bit-serial
// restoring divider (capacity over tier divider) then yields one quotient bit
// per cycle until its step count is reached and flags done; an update state
// commits state and fills the output register. A new update is taken the cycle
// after that, so no new update is taken while one is in flight; if the
// previous result is still held, the update cycle waits for it to leave.
// Configuration goes over the APB port at byte address 8*index; the user must
// write it only while no update is in flight, as the block does not enforce it.
module battery_charge_limit_controller_unit #(
	parameter int unsigned TRIM_INTERVAL_S = 60
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bclc_pkg::ADDR_W-1:0] paddr,
	input  logic [bclc_pkg::DATA_W-1:0] pwdata,
	output logic [bclc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	bclc_in_if.sink                     in_ch,
	bclc_out_if.source                  out_ch
);
	import bclc_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	bclc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bclc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	bclc_datapath #(
		.TRIM_INTERVAL_S (TRIM_INTERVAL_S)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.status            (status),
		.soc_percent       (in_ch.soc_percent),
		.pack_voltage      (in_ch.pack_voltage),
		.pack_current_ma   (in_ch.pack_current_ma),
		.now_seconds       (in_ch.now_seconds),
		.charge_limit_ma   (out_ch.charge_limit_ma),
		.charge_allowed    (out_ch.charge_allowed),
		.discharge_allowed (out_ch.discharge_allowed),
		.tier              (out_ch.tier),
		.settings_changed  (out_ch.settings_changed)
	);

endmodule

// ----- rtl/core/bclc_checker.sv -----
module bclc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  tier
);
	import bclc_pkg::*;

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// One update in flight: no new transfer right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// A result cannot appear in the cycle right after a transfer in
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	// Reported tier is a defined code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tier == TIER_BULK || tier == TIER_ONE || tier == TIER_TWO))
		else $error("undefined tier code");

endmodule

bind battery_charge_limit_controller_unit bclc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.tier      (out_ch.tier)
);
